>>> rtl/prd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prd_pkg;

    // Widths of the stream beats.
    localparam int IN_W  = 32;
    localparam int OUT_W = 168;

    // Default pixel matrix size.
    localparam int NUM_COLUMNS_DEF = 80;
    localparam int NUM_ROWS_DEF    = 336;

    // Entries in the queue between the decoder and the counter stage.
    localparam int QUEUE_DEPTH = 2;

    // Record type codes found in bits 23..16 of a non-trigger word.
    localparam logic [7:0] REC_BASE    = 8'hE8;
    localparam logic [7:0] REC_HEADER  = REC_BASE | 8'h01;
    localparam logic [7:0] REC_ADDRESS = REC_BASE | 8'h02;
    localparam logic [7:0] REC_VALUE   = REC_BASE | 8'h04;
    localparam logic [7:0] REC_SERVICE = REC_BASE | 8'h07;

    // A tot2 of all ones marks a hit without a second pixel.
    localparam logic [3:0] TOT_NO_SECOND = 4'hF;

    // Decoded record kind as it leaves the block.
    typedef enum logic [2:0] {
        KIND_TRIGGER     = 3'd0,
        KIND_HEADER      = 3'd1,
        KIND_ADDRESS     = 3'd2,
        KIND_VALUE       = 3'd3,
        KIND_SERVICE     = 3'd4,
        KIND_VALID_HIT   = 3'd5,
        KIND_INVALID_HIT = 3'd6
    } kind_t;

    // One decoded word, before the counters are applied.
    typedef struct packed {
        kind_t       kind;
        logic [6:0]  channel;
        logic [30:0] payload;
        logic [5:0]  lv1id_or_code;
        logic        flag;
        logic [6:0]  column;
        logic [8:0]  row;
        logic [3:0]  tot1;
        logic [3:0]  tot2;
    } dec_t;

endpackage

`default_nettype wire

>>> rtl/prd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module prd_front #(
    parameter int NUM_COLUMNS = prd_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = prd_pkg::NUM_ROWS_DEF
) (
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [prd_pkg::IN_W-1:0] s_tdata,
    output logic                         push,
    input  wire logic                    queue_full,
    output prd_pkg::dec_t                push_item
);

    localparam logic [6:0] COL_LIMIT      = 7'(NUM_COLUMNS);
    localparam logic [8:0] ROW_LIMIT      = 9'(NUM_ROWS);
    localparam logic [8:0] ROW_LIMIT_PAIR = 9'(NUM_ROWS - 1);

    logic [7:0] rec_type;
    logic [6:0] col_raw;
    logic [8:0] row_raw;
    logic [8:0] row_limit;
    logic       hit_ok;

    // A word is taken whenever the queue has room.
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    assign rec_type = s_tdata[23:16];
    assign col_raw  = s_tdata[23:17];
    assign row_raw  = s_tdata[16:8];

    // Raw column and row are one-based, so zero is out of range.
    assign row_limit = (s_tdata[3:0] == prd_pkg::TOT_NO_SECOND) ? ROW_LIMIT : ROW_LIMIT_PAIR;
    assign hit_ok    = (col_raw != 7'd0) && (col_raw <= COL_LIMIT) &&
                       (row_raw != 9'd0) && (row_raw <= row_limit);

    // Classify the word and pull out the fields of its kind.
    always_comb begin
        push_item = '0;
        if (s_tdata[31]) begin
            push_item.kind    = prd_pkg::KIND_TRIGGER;
            push_item.payload = s_tdata[30:0];
        end else begin
            push_item.channel = s_tdata[30:24];
            unique case (rec_type)
                prd_pkg::REC_HEADER: begin
                    push_item.kind          = prd_pkg::KIND_HEADER;
                    push_item.payload       = {21'd0, s_tdata[9:0]};
                    push_item.lv1id_or_code = {1'b0, s_tdata[14:10]};
                    push_item.flag          = s_tdata[15];
                end
                prd_pkg::REC_ADDRESS: begin
                    push_item.kind    = prd_pkg::KIND_ADDRESS;
                    push_item.payload = {16'd0, s_tdata[14:0]};
                    push_item.flag    = s_tdata[15];
                end
                prd_pkg::REC_VALUE: begin
                    push_item.kind    = prd_pkg::KIND_VALUE;
                    push_item.payload = {15'd0, s_tdata[15:0]};
                end
                prd_pkg::REC_SERVICE: begin
                    push_item.kind          = prd_pkg::KIND_SERVICE;
                    push_item.payload       = {21'd0, s_tdata[9:0]};
                    push_item.lv1id_or_code = s_tdata[15:10];
                end
                default: begin
                    push_item.tot1 = s_tdata[7:4];
                    push_item.tot2 = s_tdata[3:0];
                    if (hit_ok) begin
                        push_item.kind   = prd_pkg::KIND_VALID_HIT;
                        push_item.column = col_raw - 7'd1;
                        push_item.row    = row_raw - 9'd1;
                    end else begin
                        push_item.kind = prd_pkg::KIND_INVALID_HIT;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/prd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module prd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire prd_pkg::dec_t push_item,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output prd_pkg::dec_t      pop_item
);

    localparam int DEPTH = prd_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    prd_pkg::dec_t      entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_item  = entries_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/prd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module prd_back (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     item_valid,
    output logic                          item_pop,
    input  wire prd_pkg::dec_t            item,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [prd_pkg::OUT_W-1:0]     m_tdata
);

    logic [31:0]   header_count_reg, header_count_next;
    logic [31:0]   hit_count_reg, hit_count_next;
    logic [31:0]   invalid_count_reg, invalid_count_next;
    logic          m_tvalid_reg, m_tvalid_next;
    prd_pkg::dec_t out_item_reg;
    logic [31:0]   out_header_reg, out_hit_reg, out_invalid_reg;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        sat_inc = (c == '1) ? c : c + 32'd1;
    endfunction

    // Take the next record whenever the output register is free or draining.
    assign item_pop = item_valid && (!m_tvalid_reg || m_tready);

    // Counter update for the record being taken.
    always_comb begin
        header_count_next  = header_count_reg;
        hit_count_next     = hit_count_reg;
        invalid_count_next = invalid_count_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;
        if (item_pop) begin
            m_tvalid_next = 1'b1;
            if (item.kind == prd_pkg::KIND_HEADER) begin
                header_count_next = sat_inc(header_count_reg);
            end
            if (item.kind == prd_pkg::KIND_VALID_HIT) begin
                hit_count_next = sat_inc(hit_count_reg);
            end
            if (item.kind == prd_pkg::KIND_INVALID_HIT) begin
                invalid_count_next = sat_inc(invalid_count_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_count_reg  <= '0;
            hit_count_reg     <= '0;
            invalid_count_reg <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            header_count_reg  <= header_count_next;
            hit_count_reg     <= hit_count_next;
            invalid_count_reg <= invalid_count_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // Output beat register, loaded with the counts after this record.
    always_ff @(posedge aclk) begin
        if (item_pop) begin
            out_item_reg    <= item;
            out_header_reg  <= header_count_next;
            out_hit_reg     <= hit_count_next;
            out_invalid_reg <= invalid_count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_invalid_reg, out_hit_reg, out_header_reg,
                       out_item_reg.tot2, out_item_reg.tot1, out_item_reg.row,
                       out_item_reg.column, out_item_reg.flag,
                       out_item_reg.lv1id_or_code, out_item_reg.payload,
                       out_item_reg.channel, out_item_reg.kind};

endmodule

`default_nettype wire

>>> rtl/pixel_readout_word_decoder.sv
// Pixel readout word decoder.
// The slave channel takes one 32-bit readout word per beat on s_tdata. The
// master channel gives one decoded record per word, in order, on m_tdata.
// A front stage classifies each word (trigger, data header, address, value,
// service or pixel hit) and checks hit coordinates against the matrix size
// set by NUM_COLUMNS and NUM_ROWS. A two-entry queue feeds a back stage that
// keeps saturating counts of headers, valid hits and invalid hits and holds
// the result in an output register.
// An accepted word goes through a queue entry and then the output register.
// Throughput is one word per cycle while m_tready stays high; the combinational
// classifier and the counter update both keep up with that.
// When the receiver stalls, the output register holds its beat, the queue
// fills, and s_tready drops once both queue entries are taken.
// A synchronous reset with aresetn low clears the counters, empties the
// queue and drops m_tvalid; the block takes words in the cycle after.
`timescale 1ns / 1ps
`default_nettype none

module pixel_readout_word_decoder #(
    parameter int NUM_COLUMNS = prd_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = prd_pkg::NUM_ROWS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // word[31:0]
    input  wire logic [prd_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // kind[2:0], channel[9:3], payload[40:10], lv1id_or_code[46:41],
    // flag[47], column[54:48], row[63:55], tot1[67:64], tot2[71:68],
    // header_total[103:72], hit_total[135:104], invalid_total[167:136]
    output logic [prd_pkg::OUT_W-1:0]      m_tdata
);

    prd_pkg::dec_t push_item, pop_item;
    logic          push, queue_full, pop, queue_not_empty;

    // Classifier.
    prd_front #(
        .NUM_COLUMNS(NUM_COLUMNS),
        .NUM_ROWS   (NUM_ROWS)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .queue_full(queue_full),
        .push_item (push_item)
    );

    // Queue between classifier and counter stage.
    prd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .full     (queue_full),
        .pop      (pop),
        .not_empty(queue_not_empty),
        .pop_item (pop_item)
    );

    // Counters and output register.
    prd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .item_valid(queue_not_empty),
        .item_pop  (pop),
        .item      (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire
